/* sv/gthi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gthi_pkg
// shared types and constants of the grid height interpolator
// ----------------------------------------------------------------------------
package gthi_pkg;

    localparam int unsigned H_W   = 24;
    localparam int unsigned CNT_W = 6;

    typedef enum logic [1:0] {
        t_reg_cells_x    = 2'd0,
        t_reg_cells_y    = 2'd1,
        t_reg_cell_len_x = 2'd2,
        t_reg_cell_len_y = 2'd3
    } t_reg_idx;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic signed [H_W-1:0] H_MAX = 24'sh7FFFFF;
    localparam logic signed [H_W-1:0] H_MIN = -24'sh800000;

endpackage
`default_nettype wire

/* sv/gthi_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gthi_div
// pipelined restoring divider, one quotient bit per stage, carries a tag
// ----------------------------------------------------------------------------
module gthi_div #(
    parameter int unsigned NUM_W = 56,
    parameter int unsigned DEN_W = 24,
    parameter int unsigned TAG_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic      [NUM_W-1:0] o_quot,
    output logic      [TAG_W-1:0] o_tag
);

    logic [NUM_W-1:0] r_num [NUM_W+1];
    logic [DEN_W:0]   r_rem [NUM_W+1];
    logic [DEN_W-1:0] r_den [NUM_W+1];
    logic [TAG_W-1:0] r_tag [NUM_W+1];
    logic             r_vld [NUM_W+1];

    always_comb begin
        r_num[0] = i_num;
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_tag[0] = i_tag;
        r_vld[0] = i_valid;
    end

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W+1:0] n_try;
        logic [DEN_W+1:0] n_sh;
        always_comb begin
            n_sh  = {r_rem[s], r_num[s][NUM_W-1]};
            n_try = n_sh - {2'b00, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_en) begin
                r_rem[s+1] <= n_try[DEN_W+1] ? n_sh[DEN_W:0] : n_try[DEN_W:0];
                r_num[s+1] <= {r_num[s][NUM_W-2:0], ~n_try[DEN_W+1]};
                r_den[s+1] <= r_den[s];
                r_tag[s+1] <= r_tag[s];
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quot  = r_num[NUM_W];
    assign o_tag   = r_tag[NUM_W];

endmodule
`default_nettype wire

/* sv/grid_triangle_height_interp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_triangle_height_interp
// triangulated height grid, node writes and pipelined point queries
// ----------------------------------------------------------------------------
// Takes one item per clock when the output is free. A write item stores a node
// height and gives no result. A query passes 87 register stages (input stage,
// 24 cell index divider stages, five single stages, 56 rounded slope divider
// stages and the output register) on its way to the result. Results keep item
// order; a stalled output freezes the whole pipeline. Node heights sit in four
// banked memories (by column and row parity) so the four corners of a cell are
// read in the same cycle; a write lands when it leaves the index divider, at
// the point where queries read, so a query sees exactly the writes accepted
// before it. Unwritten nodes read as undefined.
module grid_triangle_height_interp #(
    parameter int unsigned MAX_NODES_X = 64,
    parameter int unsigned MAX_NODES_Y = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: node_x[5:0], node_y[11:6], node_height[35:12], query_x[59:36],
    // query_y[83:60], zeros to 88
    input  wire logic [87:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // height
    output logic             m_axis_tuser    // outside_face
);

    localparam int unsigned HW = gthi_pkg::H_W;
    localparam int unsigned BX = (MAX_NODES_X + 1) / 2;
    localparam int unsigned BY = (MAX_NODES_Y + 1) / 2;
    localparam int unsigned BD  = BX * BY;
    localparam int unsigned BAW = (BD > 1) ? $clog2(BD) : 1;
    localparam int unsigned NW  = 56;

    // ---------------- configuration
    logic [5:0]  r_cells_x, r_cells_y;
    logic [23:0] r_len_x, r_len_y;
    logic        n_cfg_wr;
    assign pready   = 1'b1;
    assign n_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= 6'd1;
            r_cells_y <= 6'd1;
            r_len_x   <= 24'd4096;
            r_len_y   <= 24'd4096;
        end else if (n_cfg_wr) begin
            unique case (paddr[3:2])
                gthi_pkg::t_reg_cells_x:    r_cells_x <= pwdata[5:0];
                gthi_pkg::t_reg_cells_y:    r_cells_y <= pwdata[5:0];
                gthi_pkg::t_reg_cell_len_x: r_len_x   <= pwdata[23:0];
                gthi_pkg::t_reg_cell_len_y: r_len_y   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            gthi_pkg::t_reg_cells_x:    prdata = {26'd0, r_cells_x};
            gthi_pkg::t_reg_cells_y:    prdata = {26'd0, r_cells_y};
            gthi_pkg::t_reg_cell_len_x: prdata = {8'd0, r_len_x};
            gthi_pkg::t_reg_cell_len_y: prdata = {8'd0, r_len_y};
            default:                    prdata = '0;
        endcase
    end

    logic [5:0]  w_nx, w_ny;
    logic [23:0] w_lx, w_ly;
    assign w_nx = (r_cells_x == '0) ? 6'd1 : r_cells_x;
    assign w_ny = (r_cells_y == '0) ? 6'd1 : r_cells_y;
    assign w_lx = (r_len_x == '0) ? 24'd1 : r_len_x;
    assign w_ly = (r_len_y == '0) ? 24'd1 : r_len_y;

    // ---------------- pipeline enable, output register
    logic r_ov;
    logic w_en;
    assign w_en          = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    logic        w_acc;
    logic [5:0]  w_in_nx, w_in_ny;
    logic [23:0] w_in_h, w_qx, w_qy;
    assign w_acc   = s_axis_tvalid & w_en;
    assign w_in_nx = s_axis_tdata[5:0];
    assign w_in_ny = s_axis_tdata[11:6];
    assign w_in_h  = s_axis_tdata[35:12];
    assign w_qx    = s_axis_tdata[59:36];
    assign w_qy    = s_axis_tdata[83:60];

    // ---------------- stage 1: extent check, latch item
    logic        r1_v, r1_out, r1_wr;
    logic [23:0] r1_x, r1_y, r1_wh;
    logic [5:0]  r1_wnx, r1_wny;
    logic [29:0] w_ext_x, w_ext_y;
    assign w_ext_x = 30'(w_nx) * 30'(w_lx);
    assign w_ext_y = 30'(w_ny) * 30'(w_ly);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r1_wr <= 1'b0;
        end else if (w_en) begin
            r1_v  <= w_acc && (s_axis_tuser == gthi_pkg::FUNC_QUERY);
            r1_wr <= w_acc && (s_axis_tuser == gthi_pkg::FUNC_WRITE)
                     && (32'(w_in_nx) < MAX_NODES_X) && (32'(w_in_ny) < MAX_NODES_Y);
        end
        if (w_en) begin
            r1_out <= (30'(w_qx) > w_ext_x) || (30'(w_qy) > w_ext_y);
            r1_x   <= w_qx;
            r1_y   <= w_qy;
            r1_wnx <= w_in_nx;
            r1_wny <= w_in_ny;
            r1_wh  <= w_in_h;
        end
    end

    // ---------------- cell index dividers (24 stages)
    // the y lane carries node writes so they reach the banks in item order
    logic        wdx_v, wdy_v;
    logic [23:0] wdx_q, wdy_q;
    logic [48:0] wdx_t;
    logic [35:0] wdy_t;  // node_x, node_y, height
    gthi_div #(.NUM_W(24), .DEN_W(24), .TAG_W(49)) u_divx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r1_v),
        .i_num(r1_x), .i_den(w_lx), .i_tag({r1_out, r1_x, r1_y}),
        .o_valid(wdx_v), .o_quot(wdx_q), .o_tag(wdx_t));
    gthi_div #(.NUM_W(24), .DEN_W(24), .TAG_W(36)) u_divy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r1_wr),
        .i_num(r1_y), .i_den(w_ly), .i_tag({r1_wnx, r1_wny, r1_wh}),
        .o_valid(wdy_v), .o_quot(wdy_q), .o_tag(wdy_t));

    // ---------------- node write into four parity banks
    logic [HW-1:0] r_bank [4][BD];
    logic          w_wr;
    logic [1:0]    w_wb;
    logic [BAW-1:0] w_wa;
    assign w_wr = w_en && wdy_v;
    assign w_wb = {wdy_t[24], wdy_t[30]};
    assign w_wa = BAW'(32'(wdy_t[35:31]) * BY + 32'(wdy_t[29:25]));

    // ---------------- stage 2: clamp index
    logic        r2_v, r2_out;
    logic [5:0]  r2_ix, r2_iy;
    logic [23:0] r2_x, r2_y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= wdx_v;
        end
        if (w_en) begin
            r2_out <= wdx_t[48];
            r2_x   <= wdx_t[47:24];
            r2_y   <= wdx_t[23:0];
            r2_ix  <= (wdx_q >= 24'(w_nx)) ? w_nx - 6'd1 : wdx_q[5:0];
            r2_iy  <= (wdy_q >= 24'(w_ny)) ? w_ny - 6'd1 : wdy_q[5:0];
        end
    end

    // ---------------- stage 3: fraction, corner memory reads
    logic        r3_v, r3_out;
    logic [23:0] r3_fx, r3_fy;
    logic [1:0]  r3_par;
    logic [3:0]  r3_ok;  // corners 0..3 inside storage
    logic [HW-1:0] r3_bk [4];
    logic [6:0]  w_i1, w_j1;
    assign w_i1 = 7'(r2_ix) + 7'd1;
    assign w_j1 = 7'(r2_iy) + 7'd1;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [6:0] w_ci, w_cj;
        // bank b holds nodes with column parity b[0] and row parity b[1]
        assign w_ci = (r2_ix[0] == b[0]) ? 7'(r2_ix) : w_i1;
        assign w_cj = (r2_iy[0] == b[1]) ? 7'(r2_iy) : w_j1;
        always_ff @(posedge i_clk) begin
            if (w_wr && (w_wb == 2'(b))) begin
                r_bank[b][w_wa] <= wdy_t[23:0];
            end
            if (w_en) begin
                r3_bk[b] <= r_bank[b][BAW'(32'(w_ci[6:1]) * BY + 32'(w_cj[6:1]))];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
        if (w_en) begin
            r3_out <= r2_out;
            r3_fx  <= r2_x - 24'(30'(r2_ix) * 30'(w_lx));
            r3_fy  <= r2_y - 24'(30'(r2_iy) * 30'(w_ly));
            r3_par <= {r2_iy[0], r2_ix[0]};
            r3_ok[0] <= 1'b1;
            r3_ok[1] <= 32'(w_i1) < MAX_NODES_X;
            r3_ok[2] <= (32'(w_i1) < MAX_NODES_X) && (32'(w_j1) < MAX_NODES_Y);
            r3_ok[3] <= 32'(w_j1) < MAX_NODES_Y;
        end
    end

    // corner k sits at column offset ox and row offset oy, bank = parity xor offset
    logic signed [HW-1:0] w_z [4];
    always_comb begin
        w_z[0] = r3_ok[0] ? r3_bk[{r3_par[1], r3_par[0]}]   : '0;
        w_z[1] = r3_ok[1] ? r3_bk[{r3_par[1], ~r3_par[0]}]  : '0;
        w_z[2] = r3_ok[2] ? r3_bk[{~r3_par[1], ~r3_par[0]}] : '0;
        w_z[3] = r3_ok[3] ? r3_bk[{~r3_par[1], r3_par[0]}]  : '0;
    end

    // ---------------- stage 4: products for triangle choice
    logic        r4_v, r4_out, r4_diag;
    logic [23:0] r4_fx, r4_fy;
    logic signed [HW-1:0] r4_z [4];
    logic [47:0] r4_fylx, r4_fxly, r4_lxly;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
        if (w_en) begin
            r4_out  <= r3_out;
            r4_fx   <= r3_fx;
            r4_fy   <= r3_fy;
            r4_z    <= w_z;
            r4_diag <= (26'(w_z[0]) + 26'(w_z[2]) - 26'(w_z[1])) > 26'(w_z[3]);
            r4_fylx <= 48'(r3_fy) * 48'(w_lx);
            r4_fxly <= 48'(r3_fx) * 48'(w_ly);
            r4_lxly <= 48'(w_lx) * 48'(w_ly);
        end
    end

    // ---------------- stage 5: pick triangle, base and slopes
    logic        r5_v, r5_out;
    logic [23:0] r5_fx, r5_fy;
    logic signed [26:0] r5_base;
    logic signed [25:0] r5_dx, r5_dy;
    logic signed [25:0] w_d10, w_d30, w_d23, w_d21;
    assign w_d10 = 26'(r4_z[1]) - 26'(r4_z[0]);
    assign w_d30 = 26'(r4_z[3]) - 26'(r4_z[0]);
    assign w_d23 = 26'(r4_z[2]) - 26'(r4_z[3]);
    assign w_d21 = 26'(r4_z[2]) - 26'(r4_z[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r4_v;
        end
        if (w_en) begin
            r5_out <= r4_out;
            r5_fx  <= r4_fx;
            r5_fy  <= r4_fy;
            if (r4_diag) begin
                r5_base <= 27'(r4_z[0]);
                if (r4_fylx > r4_fxly) begin
                    r5_dx <= w_d23;
                    r5_dy <= w_d30;
                end else begin
                    r5_dx <= w_d10;
                    r5_dy <= w_d21;
                end
            end else if ((49'(r4_fxly) + 49'(r4_fylx)) < 49'(r4_lxly)) begin
                r5_base <= 27'(r4_z[0]);
                r5_dx   <= w_d10;
                r5_dy   <= w_d30;
            end else begin
                r5_base <= 27'(r4_z[1]) + 27'(r4_z[3]) - 27'(r4_z[2]);
                r5_dx   <= w_d23;
                r5_dy   <= w_d21;
            end
        end
    end

    // ---------------- stage 6: products, magnitudes with rounding offset
    logic        r6_v;
    logic [1:0]  r6_neg;
    logic [NW-1:0] r6_mx, r6_my;
    logic [32:0] r6_tag;  // out, base
    logic signed [50:0] w_px, w_py;
    logic [50:0] w_ax, w_ay;
    assign w_px = $signed({1'b0, r5_fx}) * r5_dx;
    assign w_py = $signed({1'b0, r5_fy}) * r5_dy;
    assign w_ax = w_px[50] ? 51'(-w_px) : 51'(w_px);
    assign w_ay = w_py[50] ? 51'(-w_py) : 51'(w_py);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= r5_v;
        end
        if (w_en) begin
            r6_neg <= {w_py[50], w_px[50]};
            r6_mx  <= NW'(w_ax) + NW'(w_lx[23:1]);
            r6_my  <= NW'(w_ay) + NW'(w_ly[23:1]);
            r6_tag <= {6'd0, r5_out, 26'(r5_base)};
        end
    end

    // ---------------- rounded slope divisions
    logic          wqx_v, wqy_v;
    logic [NW-1:0] wqx, wqy;
    logic [35:0]   wqx_t, wqy_t;
    gthi_div #(.NUM_W(NW), .DEN_W(24), .TAG_W(36)) u_divtx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r6_v),
        .i_num(r6_mx), .i_den(w_lx), .i_tag({1'b0, r6_neg, r6_tag}),
        .o_valid(wqx_v), .o_quot(wqx), .o_tag(wqx_t));
    gthi_div #(.NUM_W(NW), .DEN_W(24), .TAG_W(36)) u_divty (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r6_v),
        .i_num(r6_my), .i_den(w_ly), .i_tag({1'b0, r6_neg, r6_tag}),
        .o_valid(wqy_v), .o_quot(wqy), .o_tag(wqy_t));

    // ---------------- stage 7: sum, saturate, output register
    logic signed [35:0] w_tx, w_ty, w_sum;
    logic [23:0] r_oh;
    logic        r_oo;
    assign w_tx  = wqx_t[33] ? -$signed(36'(wqx)) : $signed(36'(wqx));
    assign w_ty  = wqx_t[34] ? -$signed(36'(wqy)) : $signed(36'(wqy));
    assign w_sum = 36'($signed(wqx_t[25:0])) + w_tx + w_ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= wqx_v;
        end
        if (w_en) begin
            r_oo <= wqx_t[26];
            if (wqx_t[26]) begin
                r_oh <= '0;
            end else if (w_sum > 36'(gthi_pkg::H_MAX)) begin
                r_oh <= gthi_pkg::H_MAX;
            end else if (w_sum < 36'(gthi_pkg::H_MIN)) begin
                r_oh <= gthi_pkg::H_MIN;
            end else begin
                r_oh <= w_sum[23:0];
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_oh;
    assign m_axis_tuser  = r_oo;

`ifndef SYNTHESIS
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wqx_v == wqy_v) && !(wdx_v && wdy_v))
        else $error("divider lanes out of step");
    a_tag_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wqx_v |-> (wqx_t == wqy_t))
        else $error("slope divider tags differ");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_axis_tready) |=> (r_ov && $stable(r_oh) && $stable(r_oo)))
        else $error("result changed under stall");
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oo) |-> (r_oh == '0))
        else $error("outside result not zero");
`endif

endmodule
`default_nettype wire
